[hdl/lsa_pkg.sv]
// Shared constants and types for the light sensor average and autoscale block.
`default_nettype none
package lsa_pkg;

  localparam int MEAN_DEPTH = 32;
  localparam int SAMPLE_W   = 10;
  localparam int IDX_W      = (MEAN_DEPTH > 1) ? $clog2(MEAN_DEPTH) : 1;
  localparam int TOT_W      = SAMPLE_W + IDX_W;
  localparam int NUM_W      = 2 * SAMPLE_W;
  localparam int DIV_STEPS  = SAMPLE_W;
  localparam int CNT_W      = $clog2(DIV_STEPS + 1);

  localparam logic [SAMPLE_W-1:0] FULL_SCALE = 10'd1023;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_MEAN = 5'b00100,
    S_LOAD = 5'b01000,
    S_DIV  = 5'b10000
  } state_t;

endpackage
`default_nettype wire

[hdl/lsa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lsa_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 32
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic                                         re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[hdl/lsa_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module lsa_div (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [lsa_pkg::NUM_W-1:0]    dividend,
  input  wire logic [lsa_pkg::SAMPLE_W-1:0] divisor,
  output      logic                         done,
  output      logic [lsa_pkg::SAMPLE_W-1:0] quotient
);

  logic [lsa_pkg::SAMPLE_W-1:0] rem;
  logic [lsa_pkg::SAMPLE_W-1:0] low;
  logic [lsa_pkg::SAMPLE_W-1:0] dvs;
  logic [lsa_pkg::CNT_W-1:0]    count;
  logic [lsa_pkg::SAMPLE_W:0]   trial;
  logic                         fits;

  // shift in the next dividend bit and try the subtract
  assign trial = {rem, low[lsa_pkg::SAMPLE_W-1]};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= !start && (count == lsa_pkg::CNT_W'(1));
      if (start) begin
        count <= lsa_pkg::CNT_W'(lsa_pkg::DIV_STEPS);
      end else if (count != '0) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // the upper half is below the divisor, so the quotient fits in SAMPLE_W bits
      rem      <= dividend[lsa_pkg::NUM_W-1:lsa_pkg::SAMPLE_W];
      low      <= dividend[lsa_pkg::SAMPLE_W-1:0];
      dvs      <= divisor;
      quotient <= '0;
    end else if (count != '0) begin
      rem      <= fits ? lsa_pkg::SAMPLE_W'(trial - {1'b0, dvs})
                       : trial[lsa_pkg::SAMPLE_W-1:0];
      low      <= {low[lsa_pkg::SAMPLE_W-2:0], 1'b0};
      quotient <= {quotient[lsa_pkg::SAMPLE_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

[hdl/light_sensor_average_autoscale.sv]
// Top level: sample ring, running mean, min/max bounds and inverse brightness map.
//
//   channel   direction  handshake               payload
//   input     in         in_valid / in_stall     sample
//   output    out        out_valid / out_stall   brightness, mean_level, range_empty
//   config    in         cfg_write_enable        cfg_write_data (autoscale_enable)
//
// An item goes from input transfer to a loaded result register through a ring read,
// a mean step, a setup step, the steps of the bit-serial divider and a load of the
// result. A new sample is taken only once the previous result is loaded. The result
// register holds while out_stall is high; a following item waits in its last step
// until the register frees. Reset clears the ring valid bits at once, so no clearing
// pass is needed.
`default_nettype none
module light_sensor_average_autoscale (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write_enable,
  input  wire logic                         cfg_write_data,
  input  wire logic                         in_valid,
  output      logic                         in_stall,
  input  wire logic [lsa_pkg::SAMPLE_W-1:0] sample,
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      logic [lsa_pkg::SAMPLE_W-1:0] brightness,
  output      logic [lsa_pkg::SAMPLE_W-1:0] mean_level,
  output      logic                         range_empty
);

  lsa_pkg::state_t state;

  logic                              autoscale_enable;
  logic [lsa_pkg::SAMPLE_W-1:0]      sample_hold;
  logic [lsa_pkg::IDX_W-1:0]         ring_position;
  logic [lsa_pkg::MEAN_DEPTH-1:0]    ring_valid;
  logic [lsa_pkg::TOT_W-1:0]         running_total;
  logic [lsa_pkg::SAMPLE_W-1:0]      lowest_seen;
  logic [lsa_pkg::SAMPLE_W-1:0]      highest_seen;
  logic [lsa_pkg::SAMPLE_W-1:0]      mean;
  logic                              empty;

  logic [lsa_pkg::SAMPLE_W-1:0]      ring_rdata;
  logic [lsa_pkg::SAMPLE_W-1:0]      old_sample;
  logic                              in_xfer;
  logic                              out_free;
  logic                              out_load;
  logic [lsa_pkg::TOT_W-1:0]         total_q;
  logic [lsa_pkg::SAMPLE_W-1:0]      mean_next;
  logic [lsa_pkg::SAMPLE_W-1:0]      lo;
  logic [lsa_pkg::SAMPLE_W-1:0]      hi;
  logic [lsa_pkg::SAMPLE_W-1:0]      diff;
  logic [lsa_pkg::NUM_W-1:0]         num;
  logic [lsa_pkg::SAMPLE_W-1:0]      span;
  logic                              div_start;
  logic                              div_done;
  logic                              div_ready;
  logic [lsa_pkg::SAMPLE_W-1:0]      quotient;

  assign in_stall = (state != lsa_pkg::S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  // load the result register once the quotient is in and the register is free
  assign out_load = (state == lsa_pkg::S_DIV) && (div_done || div_ready) && out_free;

  lsa_ram #(
    .WIDTH (lsa_pkg::SAMPLE_W),
    .DEPTH (lsa_pkg::MEAN_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (state == lsa_pkg::S_READ),
    .waddr (ring_position),
    .wdata (sample_hold),
    .re    (in_xfer),
    .raddr (ring_position),
    .rdata (ring_rdata)
  );

  // unwritten entries read as zero
  assign old_sample = ring_valid[ring_position] ? ring_rdata : '0;

  assign total_q   = running_total / lsa_pkg::TOT_W'(lsa_pkg::MEAN_DEPTH);
  assign mean_next = (total_q > lsa_pkg::TOT_W'(lsa_pkg::FULL_SCALE))
                     ? lsa_pkg::FULL_SCALE : total_q[lsa_pkg::SAMPLE_W-1:0];

  assign lo   = autoscale_enable ? lowest_seen  : '0;
  assign hi   = autoscale_enable ? highest_seen : lsa_pkg::FULL_SCALE;
  assign diff = (mean >= lo) ? mean - lo : '0;
  // diff * 1023 as a shift and subtract
  assign num  = {diff, {lsa_pkg::SAMPLE_W{1'b0}}} - lsa_pkg::NUM_W'(diff);
  assign span = (hi > lo) ? hi - lo : lsa_pkg::SAMPLE_W'(1);

  assign div_start = (state == lsa_pkg::S_LOAD);

  lsa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (num),
    .divisor  (span),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= lsa_pkg::S_IDLE;
      autoscale_enable <= 1'b1;
      ring_position    <= '0;
      ring_valid       <= '0;
      running_total    <= '0;
      lowest_seen      <= lsa_pkg::FULL_SCALE;
      highest_seen     <= '0;
      out_valid        <= 1'b0;
      div_ready        <= 1'b0;
    end else begin
      if (cfg_write_enable) begin
        autoscale_enable <= cfg_write_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        lsa_pkg::S_IDLE: begin
          if (in_xfer) begin
            state <= lsa_pkg::S_READ;
          end
        end
        lsa_pkg::S_READ: begin
          running_total <= running_total - lsa_pkg::TOT_W'(old_sample)
                           + lsa_pkg::TOT_W'(sample_hold);
          ring_valid[ring_position] <= 1'b1;
          if (ring_position == lsa_pkg::IDX_W'(lsa_pkg::MEAN_DEPTH - 1)) begin
            ring_position <= '0;
          end else begin
            ring_position <= ring_position + 1'b1;
          end
          state <= lsa_pkg::S_MEAN;
        end
        lsa_pkg::S_MEAN: begin
          if (autoscale_enable) begin
            if (mean_next < lowest_seen) begin
              lowest_seen <= mean_next;
            end
            if (mean_next > highest_seen) begin
              highest_seen <= mean_next;
            end
          end
          state <= lsa_pkg::S_LOAD;
        end
        lsa_pkg::S_LOAD: begin
          div_ready <= 1'b0;
          state     <= lsa_pkg::S_DIV;
        end
        lsa_pkg::S_DIV: begin
          if (out_load) begin
            div_ready <= 1'b0;
            state     <= lsa_pkg::S_IDLE;
          end else if (div_done) begin
            div_ready <= 1'b1;
          end
        end
        default: begin
          state <= lsa_pkg::S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sample_hold <= sample;
    end
    if (state == lsa_pkg::S_MEAN) begin
      mean <= mean_next;
    end
    if (state == lsa_pkg::S_LOAD) begin
      empty <= (hi == lo);
    end
    if (out_load) begin
      brightness  <= empty ? lsa_pkg::FULL_SCALE : lsa_pkg::FULL_SCALE - quotient;
      mean_level  <= mean;
      range_empty <= empty;
    end
  end

endmodule
`default_nettype wire

[tb/sv/tb_light_sensor_average_autoscale.sv]
// Testbench for the light sensor moving average with min/max autoscale and inverse brightness map.
module tb_light_sensor_average_autoscale;

  localparam int SAMPLE_W     = lsa_pkg::SAMPLE_W;
  localparam int MEAN_DEPTH   = lsa_pkg::MEAN_DEPTH;
  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 11;
  localparam int HOLD_CYCLES  = 400;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int FULL         = lsa_pkg::FULL_SCALE;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [SAMPLE_W-1:0] brightness;
    logic [SAMPLE_W-1:0] mean_level;
    logic                range_empty;
  } lux_reading_t;

  logic                clk              = 1'b0;
  logic                rst              = 1'b1;
  logic                cfg_write_enable = 1'b0;
  logic                cfg_write_data   = 1'b0;
  logic                in_valid         = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] sample           = '0;
  logic                out_valid;
  logic                out_stall        = 1'b0;
  logic [SAMPLE_W-1:0] brightness;
  logic [SAMPLE_W-1:0] mean_level;
  logic                range_empty;

  // Predictor state: sample history, running sum, tracked bounds and mode
  int hist_ring [MEAN_DEPTH];
  int hist_slot;
  int hist_sum;
  int floor_level;
  int ceil_level;
  bit autoscale_mode;

  lux_reading_t pending_readings[$];

  int send_idle_pct = 33;
  int rx_idle_pct   = 33;
  int hold_request  = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  int unsigned fault_count    = 0;
  int unsigned samples_sent   = 0;
  int unsigned readings_seen  = 0;
  int unsigned empty_seen     = 0;
  int unsigned fixed_samples  = 0;
  int unsigned mode_writes    = 0;

  light_sensor_average_autoscale DUT (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .sample           (sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .brightness       (brightness),
    .mean_level       (mean_level),
    .range_empty      (range_empty)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic lux_reading_t predict_reading(input logic [SAMPLE_W-1:0] s);
    lux_reading_t r;
    int mean, lo, hi, num, span, q;
    hist_sum = hist_sum - hist_ring[hist_slot] + int'(s);
    hist_ring[hist_slot] = int'(s);
    hist_slot = (hist_slot + 1) % MEAN_DEPTH;
    mean = hist_sum / MEAN_DEPTH;
    if (mean > FULL) mean = FULL;
    if (autoscale_mode) begin
      if (mean < floor_level) floor_level = mean;
      if (mean > ceil_level) ceil_level = mean;
      lo = floor_level;
      hi = ceil_level;
    end else begin
      lo = 0;
      hi = FULL;
    end
    if (hi == lo) begin
      r.brightness  = SAMPLE_W'(FULL);
      r.range_empty = 1'b1;
    end else begin
      num  = (mean >= lo) ? mean - lo : 0;
      span = (hi > lo) ? hi - lo : 1;
      q    = (num * FULL) / span;
      if (q > FULL) q = FULL;
      r.brightness  = SAMPLE_W'(FULL - q);
      r.range_empty = 1'b0;
    end
    r.mean_level = SAMPLE_W'(mean);
    return r;
  endfunction

  // Offer one sample, hold it until the transfer, then record the expected reading
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    int gap;
    gap = 0;
    if (send_idle_pct > 0) begin
      while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
      if ($urandom_range(0, 49) == 0) gap += $urandom_range(10, 30);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    do @(posedge clk); while (in_stall);
    pending_readings.push_back(predict_reading(s));
    samples_sent++;
    if (!autoscale_mode) fixed_samples++;
  endtask

  task automatic wait_readings_drained();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_autoscale(input bit en);
    wait_readings_drained();
    cfg_write_data   <= en;
    cfg_write_enable <= 1'b1;
    @(posedge clk);
    autoscale_mode = en;
    mode_writes++;
    cfg_write_enable <= 1'b0;
    @(posedge clk);
  endtask

  // Mix of steady levels with flicker, slow ramps, noise and hard extremes
  task automatic run_light_profile(input int n_items);
    int left, seg_len, kind, level, slope, v;
    left = n_items;
    while (left > 0) begin
      kind    = $urandom_range(0, 9);
      seg_len = $urandom_range(8, 64);
      if (seg_len > left) seg_len = left;
      level = $urandom_range(0, FULL);
      slope = int'($urandom_range(0, 32)) - 16;
      for (int k = 0; k < seg_len; k++) begin
        if (kind < 4)      v = level + int'($urandom_range(0, 16)) - 8;
        else if (kind < 7) v = level + slope * k;
        else if (kind < 9) v = $urandom_range(0, FULL);
        else               v = $urandom_range(0, 1) ? FULL : 0;
        if (v < 0) v = 0;
        if (v > FULL) v = FULL;
        send_sample(SAMPLE_W'(v));
      end
      left -= seg_len;
    end
  endtask

  // Right after reset the first mean sets both bounds, so the range is empty
  task automatic test_empty_range_after_reset();
    send_sample('0);
    send_sample('0);
    send_sample(10'h3FF);
    send_sample(10'h3FF);
    send_sample(10'h3FF);
    send_sample(10'h2AA);
    send_sample(10'h155);
    send_sample(10'd1);
    wait_readings_drained();
  endtask

  task automatic test_fixed_bounds();
    write_autoscale(1'b0);
    send_sample(10'h3FF);
    send_sample('0);
    send_sample(10'h2AA);
    send_sample(10'h155);
    send_sample(10'd512);
    send_sample(10'h3FF);
    for (int k = 0; k < 4; k++) send_sample(10'h3FF);
  endtask

  // Bounds survive the mode change and are widened by the next mean
  task automatic test_return_to_autoscale();
    write_autoscale(1'b1);
    for (int k = 0; k < 4; k++) send_sample(10'h3FF);
    send_sample('0);
    send_sample(10'd1022);
    wait_readings_drained();
  endtask

  task automatic test_random_autoscale();
    run_light_profile(600);
    wait_readings_drained();
  endtask

  task automatic test_random_fixed();
    write_autoscale(1'b0);
    run_light_profile(350);
    write_autoscale(1'b1);
  endtask

  // Receiver holds off while the sender keeps offering, then the sender waits for all results
  task automatic test_receiver_holdoff();
    hold_request <= hold_request + 1;
    run_light_profile(30);
    wait_readings_drained();
  endtask

  task automatic test_full_rate();
    send_idle_pct = 0;
    rx_idle_pct  <= 0;
    run_light_profile(200);
    send_idle_pct = 33;
    rx_idle_pct  <= 33;
    wait_readings_drained();
  endtask

  task automatic test_mode_toggling();
    for (int k = 0; k < 4; k++) begin
      write_autoscale(k[0] == 1'b0 ? 1'b0 : 1'b1);
      run_light_profile(50);
    end
    write_autoscale(1'b1);
    run_light_profile(30);
  endtask

  // Receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_seen != hold_request) begin
      hold_seen <= hold_request;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    lux_reading_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{brightness, mean_level, range_empty};
      readings_seen++;
      if (got.range_empty) empty_seen++;
      if (pending_readings.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("[%0t] unexpected reading: brightness=%0d mean=%0d empty=%0d",
                   $time, got.brightness, got.mean_level, got.range_empty);
      end else begin
        want = pending_readings.pop_front();
        if (got.brightness !== want.brightness || got.mean_level !== want.mean_level ||
            got.range_empty !== want.range_empty) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("[%0t] mismatch: exp brightness=%0d mean=%0d empty=%0d, got %0d %0d %0d",
                     $time, want.brightness, want.mean_level, want.range_empty,
                     got.brightness, got.mean_level, got.range_empty);
        end
      end
    end
  end

  initial begin
    for (int k = 0; k < MEAN_DEPTH; k++) hist_ring[k] = 0;
    hist_slot      = 0;
    hist_sum       = 0;
    floor_level    = FULL;
    ceil_level     = 0;
    autoscale_mode = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_range_after_reset();
    test_fixed_bounds();
    test_return_to_autoscale();
    test_random_autoscale();
    test_random_fixed();
    test_receiver_holdoff();
    test_full_rate();
    test_mode_toggling();

    wait_readings_drained();
    repeat (30) @(posedge clk);
    $display("Sent %0d samples (%0d with fixed bounds) over %0d mode writes;",
             samples_sent, fixed_samples, mode_writes);
    $display("checked %0d readings, %0d with an empty range, %0d faults.",
             readings_seen, empty_seen, fault_count);
    if (fault_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("Timed out with %0d readings outstanding", pending_readings.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
